// ===== src/keyed_window_average_table_unit_defines.svh =====
// Assertion macros for the keyed window average table RTL, used by kwat_dpath.
// Depends on the clock and reset signal names of the including module.
`ifndef KEYED_WINDOW_AVERAGE_TABLE_UNIT_DEFINES_SVH
`define KEYED_WINDOW_AVERAGE_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define KWAT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KWAT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/kwat_pkg.sv =====
// Shared types and constants for the keyed window average table.
// No dependencies.
package kwat_pkg;

   typedef enum logic [1:0] {
      FN_LOG   = 2'd0,
      FN_QUERY = 2'd1,
      FN_PATH  = 2'd2,
      FN_NONE  = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_META_RD,
      ST_META_CHK,
      ST_SMP_RD,
      ST_LOG_WR,
      ST_DIV,
      ST_ACC,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic clr_we;
      logic cap;
      logic meta_rd;
      logic smp_rd;
      logic log_wr;
      logic div_start;
      logic best_upd;
      logic sev_next;
      logic acc_upd;
      logic out_query;
      logic out_path;
   } cmd_type;

   typedef struct packed {
      logic     clr_last;
      func_type func;
      logic     bucket_ok;
      logic     full;
      logic     div_done;
      logic     sev_last;
      logic     path_last;
      logic     out_free;
   } stat_type;

   localparam int RISK_CAP       = 1000;
   localparam int RISK_AVG_MUL   = 50;
   localparam int RISK_SEV_MUL   = 300;
   localparam int RISK_EMPTY_MUL = 200;

endpackage

// ===== src/keyed_window_average_table_unit.sv =====
// A log beat to a valid bucket reads it, and the oldest sample if full, then writes;
// a query runs a 21-step serial divide, then sends its result beat; a path node divides
// once per severity, adds its best mean, and the last node sends the total. One item in
// flight. Reset clears the bucket table in a sweep before the first beat is taken; sample
// storage is not cleared. Depends on kwat_pkg, kwat_ctrl and kwat_dpath.
module keyed_window_average_table_unit import kwat_pkg::*; #(
   parameter int NODE_COUNT     = 256,
   parameter int WINDOW_LEN     = 20,
   parameter int SEVERITY_COUNT = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_node_id,
   input  logic [1:0]  req_severity_level,
   input  logic [15:0] req_delay_minutes,
   input  logic        req_path_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [15:0] rsp_average_delay,
   output logic [9:0]  rsp_risk_milli,
   output logic [31:0] rsp_path_total
);

   cmd_type  cmd;
   stat_type stat;

   kwat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   kwat_dpath #(
      .NODE_COUNT     (NODE_COUNT),
      .WINDOW_LEN     (WINDOW_LEN),
      .SEVERITY_COUNT (SEVERITY_COUNT)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_func           (req_func),
      .req_node_id        (req_node_id),
      .req_severity_level (req_severity_level),
      .req_delay_minutes  (req_delay_minutes),
      .req_path_last      (req_path_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_average_delay  (rsp_average_delay),
      .rsp_risk_milli     (rsp_risk_milli),
      .rsp_path_total     (rsp_path_total)
   );

endmodule

// ===== src/kwat_ctrl.sv =====
// Controller state machine for the keyed window average table.
// Depends on kwat_pkg; drives commands to kwat_dpath and reads its status.
module kwat_ctrl import kwat_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_META_RD;
         end
         ST_META_RD: state_in = ST_META_CHK;
         ST_META_CHK: begin
            case (stat.func)
               FN_LOG: begin
                  if (!stat.bucket_ok) state_in = ST_IDLE;
                  else if (stat.full)  state_in = ST_SMP_RD;
                  else                 state_in = ST_LOG_WR;
               end
               FN_QUERY: state_in = ST_DIV;
               FN_PATH:  state_in = ST_DIV;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_SMP_RD: state_in = ST_LOG_WR;
         ST_LOG_WR: state_in = ST_IDLE;
         ST_DIV: begin
            if (stat.div_done) begin
               if (stat.func == FN_QUERY) state_in = ST_OUT;
               else if (stat.sev_last)    state_in = ST_ACC;
               else                       state_in = ST_META_RD;
            end
         end
         ST_ACC: state_in = stat.path_last ? ST_OUT : ST_IDLE;
         ST_OUT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: cmd.clr_we = 1'b1;
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.cap   = req_valid;
         end
         ST_META_RD: cmd.meta_rd = 1'b1;
         ST_META_CHK: begin
            cmd.smp_rd    = (stat.func == FN_LOG) && stat.bucket_ok && stat.full;
            cmd.div_start = (stat.func == FN_QUERY) || (stat.func == FN_PATH);
         end
         ST_SMP_RD: cmd.smp_rd = 1'b0;
         ST_LOG_WR: cmd.log_wr = 1'b1;
         ST_DIV: begin
            cmd.best_upd = stat.div_done && (stat.func == FN_PATH);
            cmd.sev_next = stat.div_done && (stat.func == FN_PATH) && !stat.sev_last;
         end
         ST_ACC: cmd.acc_upd = 1'b1;
         ST_OUT: begin
            cmd.out_query = stat.out_free && (stat.func == FN_QUERY);
            cmd.out_path  = stat.out_free && (stat.func == FN_PATH);
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ===== src/kwat_dpath.sv =====
// Datapath for the keyed window average table: bucket and sample memories,
// serial divider, path accumulator and result register. Depends on kwat_pkg.
`include "keyed_window_average_table_unit_defines.svh"
module kwat_dpath import kwat_pkg::*; #(
   parameter int NODE_COUNT     = 256,
   parameter int WINDOW_LEN     = 20,
   parameter int SEVERITY_COUNT = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_node_id,
   input  logic [1:0]  req_severity_level,
   input  logic [15:0] req_delay_minutes,
   input  logic        req_path_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [15:0] rsp_average_delay,
   output logic [9:0]  rsp_risk_milli,
   output logic [31:0] rsp_path_total
);

   localparam int NB      = NODE_COUNT * SEVERITY_COUNT;
   localparam int BA_W    = (NB > 1) ? $clog2(NB) : 1;
   localparam int SD      = NB * WINDOW_LEN;
   localparam int SA_W    = (SD > 1) ? $clog2(SD) : 1;
   localparam int SUM_W   = 16 + $clog2(WINDOW_LEN);
   localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
   localparam int PTR_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int META_W  = SUM_W + CNT_W + PTR_W;
   localparam int SV_RAW  = $clog2(SEVERITY_COUNT + 1);
   localparam int SV_W    = (SV_RAW > 2) ? SV_RAW : 2;
   localparam int DC_W    = $clog2(SUM_W + 1);

   logic [META_W-1:0] meta_mem [NB];
   logic [15:0]       smp_mem [SD];

   logic [1:0]        func_ff;
   logic [7:0]        node_ff;
   logic [SV_W-1:0]   sev_ff;
   logic [15:0]       delay_ff;
   logic              last_ff;
   logic [META_W-1:0] meta_ff;
   logic [15:0]       smp_ff;
   logic [BA_W-1:0]   clr_ff;
   logic [SUM_W-1:0]  quot_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  dvs_ff;
   logic [DC_W-1:0]   dcnt_ff;
   logic              mzero_ff;
   logic [15:0]       best_ff;
   logic [31:0]       acc_ff;
   logic              rsp_valid_ff;
   logic              kind_ff;
   logic [15:0]       avg_ff;
   logic [9:0]        risk_ff;
   logic [31:0]       total_ff;

   logic [SUM_W-1:0]  m_sum;
   logic [CNT_W-1:0]  m_cnt;
   logic [PTR_W-1:0]  m_old;
   logic              bucket_ok;
   logic [BA_W-1:0]   bucket;
   logic [31:0]       bucket_wide;
   logic              full;
   logic [PTR_W:0]    pos_sum;
   logic [PTR_W-1:0]  pos;
   logic [PTR_W:0]    old_inc;
   logic [PTR_W-1:0]  old_next;
   logic [SA_W-1:0]   saddr;
   logic [SUM_W:0]    sum_next;
   logic [META_W-1:0] meta_wr;
   logic [CNT_W:0]    trial;
   logic              ge;
   logic [15:0]       mean;
   logic [23:0]       risk_raw;
   logic [32:0]       acc_sum;
   logic              out_free;

   assign m_sum = meta_ff[META_W-1 -: SUM_W];
   assign m_cnt = meta_ff[PTR_W +: CNT_W];
   assign m_old = meta_ff[PTR_W-1:0];

   assign bucket_ok = (32'(node_ff) < 32'(NODE_COUNT)) && (sev_ff != '0)
                      && (32'(sev_ff) <= 32'(SEVERITY_COUNT));
   assign bucket_wide = 32'(node_ff) * 32'(SEVERITY_COUNT) + 32'(sev_ff) - 32'd1;
   assign bucket = BA_W'(bucket_wide);
   assign full = (32'(m_cnt) >= 32'(WINDOW_LEN));

   assign pos_sum = (PTR_W+1)'(m_old) + (PTR_W+1)'(m_cnt);
   assign old_inc = (PTR_W+1)'(m_old) + (PTR_W+1)'(1);

   always_comb begin
      if (full) begin
         pos = m_old;
      end else if (32'(pos_sum) >= 32'(WINDOW_LEN)) begin
         pos = PTR_W'(32'(pos_sum) - 32'(WINDOW_LEN));
      end else begin
         pos = PTR_W'(pos_sum);
      end
      old_next = (32'(old_inc) >= 32'(WINDOW_LEN)) ? '0 : PTR_W'(old_inc);
   end

   assign saddr = SA_W'(bucket_wide * 32'(WINDOW_LEN) + 32'(pos));

   always_comb begin
      if (full) begin
         sum_next = (SUM_W+1)'(m_sum) - (SUM_W+1)'(smp_ff) + (SUM_W+1)'(delay_ff);
         meta_wr  = {SUM_W'(sum_next), m_cnt, old_next};
      end else begin
         sum_next = (SUM_W+1)'(m_sum) + (SUM_W+1)'(delay_ff);
         meta_wr  = {SUM_W'(sum_next), m_cnt + CNT_W'(1), m_old};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_we) begin
         meta_mem[clr_ff] <= '0;
      end else if (cmd.log_wr) begin
         meta_mem[bucket] <= meta_wr;
      end
      if (cmd.meta_rd) begin
         meta_ff <= meta_mem[bucket];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.log_wr) begin
         smp_mem[saddr] <= delay_ff;
      end
      if (cmd.smp_rd) begin
         smp_ff <= smp_mem[saddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         func_ff  <= req_func;
         node_ff  <= req_node_id;
         sev_ff   <= (func_type'(req_func) == FN_PATH) ? SV_W'(1) : SV_W'(req_severity_level);
         delay_ff <= req_delay_minutes;
         last_ff  <= req_path_last;
      end else if (cmd.sev_next) begin
         sev_ff <= sev_ff + SV_W'(1);
      end
   end

   assign trial = {rem_ff, quot_ff[SUM_W-1]};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         dcnt_ff <= DC_W'(SUM_W);
      end else if (dcnt_ff != '0) begin
         dcnt_ff <= dcnt_ff - DC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quot_ff  <= m_sum;
         rem_ff   <= '0;
         dvs_ff   <= m_cnt;
         mzero_ff <= !bucket_ok || (m_cnt == '0);
      end else if (dcnt_ff != '0) begin
         quot_ff <= {quot_ff[SUM_W-2:0], ge};
         rem_ff  <= ge ? CNT_W'(trial - {1'b0, dvs_ff}) : CNT_W'(trial);
      end
   end

   assign mean = mzero_ff ? 16'd0 : quot_ff[15:0];

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         best_ff <= '0;
      end else if (cmd.best_upd && (mean > best_ff)) begin
         best_ff <= mean;
      end
   end

   assign acc_sum = {1'b0, acc_ff} + 33'(best_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.acc_upd) begin
         acc_ff <= acc_sum[32] ? '1 : acc_sum[31:0];
      end else if (cmd.out_path) begin
         acc_ff <= '0;
      end
   end

   always_comb begin
      if (mean == '0) begin
         risk_raw = 24'(sev_ff) * 24'(RISK_EMPTY_MUL);
      end else begin
         risk_raw = 24'(mean) * 24'(RISK_AVG_MUL) + 24'(sev_ff) * 24'(RISK_SEV_MUL);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_query || cmd.out_path) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_query) begin
         kind_ff  <= 1'b0;
         avg_ff   <= mean;
         risk_ff  <= (risk_raw > 24'(RISK_CAP)) ? 10'(RISK_CAP) : risk_raw[9:0];
         total_ff <= '0;
      end else if (cmd.out_path) begin
         kind_ff  <= 1'b1;
         avg_ff   <= '0;
         risk_ff  <= '0;
         total_ff <= acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_we) begin
         clr_ff <= clr_ff + BA_W'(1);
      end
   end

   assign stat.clr_last  = (32'(clr_ff) == 32'(NB - 1));
   assign stat.func      = func_type'(func_ff);
   assign stat.bucket_ok = bucket_ok;
   assign stat.full      = full;
   assign stat.div_done  = (dcnt_ff == '0);
   assign stat.sev_last  = (32'(sev_ff) >= 32'(SEVERITY_COUNT));
   assign stat.path_last = last_ff;
   assign stat.out_free  = out_free;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_average_delay = avg_ff;
   assign rsp_risk_milli    = risk_ff;
   assign rsp_path_total    = total_ff;

   `KWAT_ASSERT_NOW(a_load_free, cmd.out_query || cmd.out_path, out_free, "result overwritten")
   `KWAT_ASSERT_NOW(a_clr_excl, cmd.clr_we, !cmd.log_wr && !cmd.cap, "access during clear")
   `KWAT_ASSERT_NEXT(a_div_busy, cmd.div_start, dcnt_ff != '0, "divider did not start")
   `KWAT_ASSERT_NOW(a_risk_cap, rsp_valid_ff, risk_ff <= 10'(RISK_CAP), "risk above cap")

endmodule

// ===== tb/kwat_checker.sv =====
// Checker for the keyed window average table: watches both channels, keeps its own
// bucket table, predicts query and path results and compares them. Depends on kwat_pkg.
module kwat_checker import kwat_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_node_id,
   input  logic [1:0]  req_severity_level,
   input  logic [15:0] req_delay_minutes,
   input  logic        req_path_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_result_kind,
   input  logic [15:0] rsp_average_delay,
   input  logic [9:0]  rsp_risk_milli,
   input  logic [31:0] rsp_path_total,
   output int          fail_count,
   output int          pending_count
);
   localparam int NODES = 256;
   localparam int WIN   = 20;
   localparam int SEVS  = 3;

   typedef struct packed {
      logic        kind;
      logic [15:0] avg;
      logic [9:0]  risk;
      logic [31:0] total;
   } answer_t;

   logic [15:0] ring [NODES*SEVS][WIN];
   logic [20:0] sum_q [NODES*SEVS];
   logic [4:0]  cnt_q [NODES*SEVS];
   logic [4:0]  old_q [NODES*SEVS];
   logic [31:0] path_acc;
   answer_t     answers_due [$];

   function automatic logic [15:0] mean_of(input logic [7:0] node, input logic [1:0] sev);
      int b;
      if (sev < 1 || sev > SEVS) return 16'd0;
      b = node * SEVS + sev - 1;
      if (cnt_q[b] == 0) return 16'd0;
      return 16'(sum_q[b] / cnt_q[b]);
   endfunction

   task automatic take_beat(input logic [1:0] fn, input logic [7:0] node,
                            input logic [1:0] sev, input logic [15:0] d, input logic last);
      int b, p, r;
      logic [15:0] a, best;
      logic [32:0] t;
      answer_t ans;
      case (fn)
         FN_LOG: begin
            if (sev >= 1 && sev <= SEVS) begin
               b = node * SEVS + sev - 1;
               if (cnt_q[b] < WIN) begin
                  p = (old_q[b] + cnt_q[b]) % WIN;
                  ring[b][p] = d;
                  cnt_q[b]++;
                  sum_q[b] += d;
               end else begin
                  p = old_q[b];
                  sum_q[b] = sum_q[b] - ring[b][p] + d;
                  ring[b][p] = d;
                  old_q[b] = (p + 1) % WIN;
               end
            end
         end
         FN_QUERY: begin
            a = mean_of(node, sev);
            r = (a == 0) ? RISK_EMPTY_MUL * sev : RISK_AVG_MUL * a + RISK_SEV_MUL * sev;
            if (r > RISK_CAP) r = RISK_CAP;
            ans = '{1'b0, a, 10'(r), 32'd0};
            answers_due = {answers_due, ans};
         end
         FN_PATH: begin
            best = 0;
            for (int s = 1; s <= SEVS; s++) begin
               a = mean_of(node, 2'(s));
               if (a > best) best = a;
            end
            t = path_acc + best;
            path_acc = t[32] ? 32'hFFFF_FFFF : t[31:0];
            if (last) begin
               ans = '{1'b1, 16'd0, 10'd0, path_acc};
               answers_due = {answers_due, ans};
               path_acc = 0;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      answer_t e;
      if (reset) begin
         for (int i = 0; i < NODES*SEVS; i++) begin
            sum_q[i] = 0; cnt_q[i] = 0; old_q[i] = 0;
         end
         path_acc = 0;
         fail_count = 0;
         answers_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result beat kind=%0d", rsp_result_kind);
            end else begin
               e = answers_due.pop_front();
               if (e.kind !== rsp_result_kind || e.avg !== rsp_average_delay ||
                   e.risk !== rsp_risk_milli || e.total !== rsp_path_total) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch exp kind=%0d avg=%0d risk=%0d total=%0d got %0d %0d %0d %0d",
                              e.kind, e.avg, e.risk, e.total, rsp_result_kind,
                              rsp_average_delay, rsp_risk_milli, rsp_path_total);
               end
            end
         end
         if (req_valid && !req_stall)
            take_beat(req_func, req_node_id, req_severity_level, req_delay_minutes,
                      req_path_last);
      end
      pending_count = answers_due.size();
   end
endmodule

// ===== tb/tb_keyed_window_average_table_unit.sv =====
// Top of the keyed window average table testbench: clock, reset, stimulus, verdict.
// Depends on kwat_pkg, keyed_window_average_table_unit and kwat_checker.
module tb_keyed_window_average_table_unit import kwat_pkg::*;;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_func = FN_LOG;
   logic [7:0]  req_node_id = 0;
   logic [1:0]  req_severity_level = 1;
   logic [15:0] req_delay_minutes = 0;
   logic        req_path_last = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_result_kind;
   logic [15:0] rsp_average_delay;
   logic [9:0]  rsp_risk_milli;
   logic [31:0] rsp_path_total;
   int          fail_count, pending_count;
   int          idle_cycles = 0;
   bit          calm = 0, hold_rsp = 0;

   keyed_window_average_table_unit uut (.*);
   kwat_checker chk (.*);

   initial forever #6 clock = ~clock;

   // stall the receiver in random bursts, or for a long stretch on request
   initial begin
      repeat (13) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_stall <= 0;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_beat(input logic [1:0] fn, input logic [7:0] node,
                            input logic [1:0] sev, input logic [15:0] d, input logic last);
      req_valid <= 1;
      req_func <= fn;
      req_node_id <= node;
      req_severity_level <= sev;
      req_delay_minutes <= d;
      req_path_last <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic maybe_gap();
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic random_beat();
      int k;
      logic [7:0] node;
      k = $urandom_range(0, 99);
      node = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      if (k < 45)
         send_beat(FN_LOG, node, 2'($urandom_range(0, 3)),
                   ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)), 0);
      else if (k < 70)
         send_beat(FN_QUERY, node, 2'($urandom_range(0, 3)), 16'($urandom), 1'($urandom));
      else if (k < 97)
         send_beat(FN_PATH, node, 2'($urandom), 16'($urandom), $urandom_range(0, 3) == 0);
      else
         send_beat(FN_NONE, node, 2'($urandom), 16'($urandom), 1'($urandom));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_beat(FN_QUERY, 0, 1, 0, 0);
      send_beat(FN_QUERY, 255, 0, 0, 0);
      send_beat(FN_LOG, 255, 3, 16'hFFFF, 0);
      send_beat(FN_LOG, 255, 3, 16'hFFFF, 1);
      send_beat(FN_LOG, 4, 0, 100, 0);
      send_beat(FN_QUERY, 255, 3, 0, 0);
      send_beat(FN_QUERY, 4, 0, 0, 0);
      for (int i = 0; i < 23; i++) send_beat(FN_LOG, 1, 2, 16'(i * 3 + 1), 0);
      send_beat(FN_QUERY, 1, 2, 0, 0);
      send_beat(FN_NONE, 1, 2, 5, 1);
      send_beat(FN_PATH, 1, 0, 0, 0);
      send_beat(FN_PATH, 7, 0, 0, 0);
      send_beat(FN_PATH, 255, 3, 0, 1);
      send_beat(FN_PATH, 2, 1, 0, 1);
      // build a large path total
      for (int i = 0; i < 20; i++) send_beat(FN_LOG, 200, 1, 16'hFFFF, 0);
      for (int i = 0; i < 4; i++) send_beat(FN_PATH, 200, 1, 0, i == 3);
      for (int n = 0; n < 1800; n++) begin
         if (n == 600) begin
            hold_rsp = 1;
            for (int j = 0; j < 8; j++) send_beat(FN_QUERY, 1, 2, 0, 0);
         end
         if (n == 1000) begin
            req_valid <= 0;
            while (pending_count != 0) @(posedge clock);
         end
         if (n == 1500) calm = 1;
         random_beat();
         maybe_gap();
      end
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ===== keyed_window_average_table_unit.f =====
+incdir+src
src/kwat_pkg.sv
src/kwat_ctrl.sv
src/kwat_dpath.sv
src/keyed_window_average_table_unit.sv
tb/kwat_checker.sv
tb/tb_keyed_window_average_table_unit.sv
